// ===== hw/rtl/bmhq_pkg.sv =====
// Shared types and constants for the binary min-heap priority queue.
// Depends on nothing; the top level imports it.
package bmhq_pkg;

    localparam int CAPACITY = 128;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int COUNT_W  = 8;
    localparam int KEY_W    = 32;
    localparam int CHILD_W  = ADDR_W + 2;

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_REMOVE = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_CMP,
        S_DN_ROOT,
        S_DN_LAST,
        S_DN_RL,
        S_DN_RR,
        S_DN_CMP,
        S_DONE
    } t_state;

endpackage

// ===== hw/rtl/bmhq_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module bmhq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/binary_min_heap_queue_top.sv =====
// Binary min-heap priority queue, top level.
// Depends on bmhq_pkg and bmhq_ram.
//
// Usage: one input word carries a command (insert or remove) and a signed
// 32-bit key. Each accepted word produces exactly one output word with a
// status, the removed key (or -1 on underflow, 0 for inserts) and the entry
// count after the operation. Both channels use valid/stall; a word moves on a
// rising edge where valid is high and stall is low.
//
// The keys live in one synchronous RAM with a registered read. An insert
// walks up from the new leaf level by level (read parent, compare and
// write). A remove first reads the root and the last entry, then walks down
// level by level (read left child, read right child, compare and write).
// Overflow and underflow go straight to the final state. Only one operation
// is in flight; o_stall is high until the block is idle again. The output
// word sits in a register, so a new input word is taken while the previous
// result waits; if the receiver keeps stalling, the next operation holds in
// its final state until the output register frees up. Reset (synchronous,
// active low) empties the queue and drops any pending output word; the RAM
// contents are not cleared.
module binary_min_heap_queue_top
    import bmhq_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_cmd,
    input  logic signed [31:0] i_value,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [1:0]         o_status,
    output logic signed [31:0] o_root_value,
    output logic [7:0]         o_entry_count
);

    t_state r_state, n_state;

    logic [COUNT_W-1:0]      r_count, n_count;
    logic [ADDR_W-1:0]       r_pos, n_pos;
    logic signed [KEY_W-1:0] r_key, n_key;
    logic signed [KEY_W-1:0] r_lval, n_lval;
    logic signed [KEY_W-1:0] r_root, n_root;
    t_status                 r_status, n_status;

    logic                    r_out_valid, n_out_valid;
    t_status                 r_out_status, n_out_status;
    logic signed [KEY_W-1:0] r_out_root, n_out_root;
    logic [COUNT_W-1:0]      r_out_count, n_out_count;

    // Memory port controls.
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [KEY_W-1:0]  mem_wdata;
    logic [ADDR_W-1:0] mem_raddr;
    logic [KEY_W-1:0]  mem_rdata;
    logic signed [KEY_W-1:0] rd_key;

    logic in_accept;
    logic out_free;

    // Child and parent indexes of the current position.
    logic [CHILD_W-1:0] left_idx, right_idx, count_ext;
    logic               left_ok, right_ok;
    logic [ADDR_W-1:0]  parent_idx;

    assign in_accept  = i_valid && (r_state == S_IDLE);
    assign out_free   = !r_out_valid || !i_stall;
    assign rd_key     = $signed(mem_rdata);

    assign left_idx   = {1'b0, r_pos, 1'b1};
    assign right_idx  = left_idx + CHILD_W'(1);
    assign count_ext  = CHILD_W'(r_count);
    assign left_ok    = left_idx < count_ext;
    assign right_ok   = right_idx < count_ext;
    assign parent_idx = ADDR_W'((r_pos - ADDR_W'(1)) >> 1);

    bmhq_ram #(
        .WIDTH(KEY_W),
        .DEPTH(CAPACITY)
    ) u_heap_ram (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_raddr(mem_raddr),
        .o_rdata(mem_rdata)
    );

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    if (t_cmd'(i_cmd) == CMD_INSERT) begin
                        n_state = (r_count >= COUNT_W'(CAPACITY)) ? S_DONE : S_UP_RD;
                    end else begin
                        n_state = (r_count == '0) ? S_DONE : S_DN_ROOT;
                    end
                end
            end
            S_UP_RD: begin
                n_state = (r_pos == '0) ? S_DONE : S_UP_CMP;
            end
            S_UP_CMP: begin
                n_state = (r_key < rd_key) ? S_UP_RD : S_DONE;
            end
            S_DN_ROOT: n_state = S_DN_LAST;
            S_DN_LAST: n_state = S_DN_RL;
            S_DN_RL: begin
                n_state = left_ok ? S_DN_RR : S_DONE;
            end
            S_DN_RR: n_state = S_DN_CMP;
            S_DN_CMP: begin
                if ((r_lval < r_key) || (right_ok && (rd_key < r_key))) begin
                    n_state = S_DN_RL;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and memory control.
    always_comb begin
        n_count      = r_count;
        n_pos        = r_pos;
        n_key        = r_key;
        n_lval       = r_lval;
        n_root       = r_root;
        n_status     = r_status;
        n_out_valid  = r_out_valid && i_stall;
        n_out_status = r_out_status;
        n_out_root   = r_out_root;
        n_out_count  = r_out_count;
        mem_we       = 1'b0;
        mem_waddr    = r_pos;
        mem_wdata    = r_key;
        mem_raddr    = '0;

        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_status = ST_OK;
                    n_root   = '0;
                    if (t_cmd'(i_cmd) == CMD_INSERT) begin
                        if (r_count >= COUNT_W'(CAPACITY)) begin
                            n_status = ST_OVERFLOW;
                        end else begin
                            n_key   = i_value;
                            n_pos   = r_count[ADDR_W-1:0];
                            n_count = r_count + COUNT_W'(1);
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_status = ST_UNDERFLOW;
                            n_root   = '1;
                        end else begin
                            // The root read starts now; the count drops to the
                            // index of the last entry.
                            n_count = r_count - COUNT_W'(1);
                        end
                    end
                end
            end
            S_UP_RD: begin
                if (r_pos == '0) begin
                    mem_we = 1'b1;
                end else begin
                    mem_raddr = parent_idx;
                end
            end
            S_UP_CMP: begin
                mem_we = 1'b1;
                if (r_key < rd_key) begin
                    // Parent moves down into the hole; the key keeps rising.
                    mem_wdata = mem_rdata;
                    n_pos     = parent_idx;
                end
            end
            S_DN_ROOT: begin
                n_root    = rd_key;
                mem_raddr = r_count[ADDR_W-1:0];
            end
            S_DN_LAST: begin
                n_key = rd_key;
                n_pos = '0;
            end
            S_DN_RL: begin
                if (left_ok) begin
                    mem_raddr = left_idx[ADDR_W-1:0];
                end else begin
                    mem_we = 1'b1;
                end
            end
            S_DN_RR: begin
                n_lval    = rd_key;
                mem_raddr = right_idx[ADDR_W-1:0];
            end
            S_DN_CMP: begin
                mem_we = 1'b1;
                // Ties keep the left child, and the key stays put on ties.
                if (right_ok && (rd_key < r_key) && (rd_key < r_lval)) begin
                    mem_wdata = mem_rdata;
                    n_pos     = right_idx[ADDR_W-1:0];
                end else if (r_lval < r_key) begin
                    mem_wdata = r_lval;
                    n_pos     = left_idx[ADDR_W-1:0];
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_root   = r_root;
                    n_out_count  = r_count;
                end
            end
            default: begin
                n_out_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos        <= n_pos;
        r_key        <= n_key;
        r_lval       <= n_lval;
        r_root       <= n_root;
        r_status     <= n_status;
        r_out_status <= n_out_status;
        r_out_root   <= n_out_root;
        r_out_count  <= n_out_count;
    end

    assign o_stall       = (r_state != S_IDLE);
    assign o_valid       = r_out_valid;
    assign o_status      = r_out_status;
    assign o_root_value  = r_out_root;
    assign o_entry_count = r_out_count;

endmodule
